// ===== rtl/badsp_pkg.sv =====
// Shared constants, register indexes and types of the block average downsample packer.
package badsp_pkg;

    localparam int PIX_W        = 5;
    localparam int BYTE_W       = 8;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_W        = 12;
    localparam int MAX_HEIGHT   = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Classification of one pixel, made by the front end.
    typedef struct packed {
        logic first;       // first pixel of a block in this row
        logic replace;     // first pixel of a block in its block row
        logic seg_end;     // last pixel of the block in this row
        logic block_done;  // last pixel of the block
        logic img_end;     // last pixel of the image
    } t_badsp_flags;

endpackage

// ===== rtl/badsp_fifo.sv =====
// Small request queue between the pixel front end and the averaging back end.
module badsp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          push, pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/badsp_front.sv =====
// Front end: size registers, raster position tracking and per-pixel classification.
module badsp_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int BLOCK_SIZE = 3,
    parameter int BCW        = 10,
    parameter int CNTW       = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [badsp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [badsp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [badsp_pkg::PIX_W-1:0]         i_pixel_value,
    input  logic                                i_clr_done,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [badsp_pkg::PIX_W-1:0]         o_pix,
    output logic [BCW-1:0]                      o_bx,
    output logic [CNTW-1:0]                     o_count,
    output badsp_pkg::t_badsp_flags             o_flags
);
    import badsp_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int XW   = ((CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W) + 1;
    localparam int CINW = $clog2(BLOCK_SIZE);

    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic [CW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    logic [CINW-1:0]         r_cin, r_rin;
    logic [BCW-1:0]          r_bx;

    logic [XW-1:0]           w_eff, col_p1;
    logic [CFG_HEIGHT_W-1:0] h_eff, row_p1;
    logic                    row_end, row_last, cin_last, rin_last;

    always_comb begin
        if (r_width == '0) begin
            w_eff = XW'(1);
        end else if (XW'(r_width) > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = CFG_HEIGHT_W'(1);
        end else if (r_height > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
            h_eff = CFG_HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign col_p1   = XW'(r_col) + XW'(1);
    assign row_p1   = CFG_HEIGHT_W'(r_row) + CFG_HEIGHT_W'(1);
    assign row_end  = (col_p1 >= w_eff);
    assign row_last = (row_p1 >= h_eff);
    assign cin_last = (r_cin == CINW'(BLOCK_SIZE - 1));
    assign rin_last = (r_rin == CINW'(BLOCK_SIZE - 1));

    assign o_in_ready = !i_q_full && i_clr_done;
    assign o_q_push   = i_in_valid && o_in_ready;
    assign o_pix      = i_pixel_value;
    assign o_bx       = r_bx;
    assign o_count    = CNTW'((CNTW'(r_cin) + CNTW'(1)) * (CNTW'(r_rin) + CNTW'(1)));

    assign o_flags.first      = (r_cin == '0);
    assign o_flags.replace    = (r_cin == '0) && (r_rin == '0);
    assign o_flags.seg_end    = cin_last || row_end;
    assign o_flags.block_done = (cin_last || row_end) && (rin_last || row_last);
    assign o_flags.img_end    = row_end && row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_WIDTH_W'(1);
            r_height <= CFG_HEIGHT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the raster position on every accepted pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cin <= '0;
            r_rin <= '0;
            r_bx  <= '0;
        end else if (o_q_push) begin
            if (row_end && row_last) begin
                r_col <= '0;
                r_row <= '0;
                r_cin <= '0;
                r_rin <= '0;
                r_bx  <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_cin <= '0;
                r_bx  <= '0;
                r_row <= r_row + ROW_W'(1);
                r_rin <= rin_last ? '0 : r_rin + CINW'(1);
            end else begin
                r_col <= r_col + CW'(1);
                r_cin <= cin_last ? '0 : r_cin + CINW'(1);
                r_bx  <= cin_last ? r_bx + BCW'(1) : r_bx;
            end
        end
    end

endmodule

// ===== rtl/badsp_back.sv =====
// Back end: block sum memory, reciprocal divide, 5-bit packing and output register.
module badsp_back #(
    parameter int MAX_WIDTH  = 2048,
    parameter int BLOCK_SIZE = 3,
    parameter int BCW        = 10,
    parameter int CNTW       = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_q_pop,
    input  logic [badsp_pkg::PIX_W-1:0]         i_pix,
    input  logic [BCW-1:0]                      i_bx,
    input  logic [CNTW-1:0]                     i_count,
    input  badsp_pkg::t_badsp_flags             i_flags,
    output logic                                o_clr_done,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [badsp_pkg::BYTE_W-1:0]        o_packed_byte,
    output logic                                o_last_byte
);
    import badsp_pkg::*;

    localparam int BLOCK_COUNT = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int LW   = $clog2(BLOCK_SIZE * BLOCK_SIZE);
    localparam int SW   = PIX_W + LW;
    localparam int K    = SW + LW;
    localparam int RW   = K + 1;
    localparam int PKW  = BYTE_W - 1;

    localparam logic [2:0] B_CLR   = 3'd0;
    localparam logic [2:0] B_RUN   = 3'd1;
    localparam logic [2:0] B_ACC   = 3'd2;
    localparam logic [2:0] B_MUL   = 3'd3;
    localparam logic [2:0] B_PACK  = 3'd4;
    localparam logic [2:0] B_FLUSH = 3'd5;

    function automatic logic [BYTE_W-1:0] flush_byte(input logic [PKW-1:0] pk,
                                                     input logic [2:0] cnt);
        logic [3:0] sh;
        sh = 4'd8 - {1'b0, cnt};
        return BYTE_W'({1'b0, pk} << sh);
    endfunction

    // Reciprocal table: floor(s / c) == (s * ceil(2^K / c)) >> K for every block sum.
    logic [RW-1:0] recip_tbl [2**CNTW];
    for (genvar c = 0; c < 2**CNTW; c++) begin : g_rcp
        if (c == 0 || c > BLOCK_SIZE * BLOCK_SIZE) begin : g_none
            assign recip_tbl[c] = '0;
        end else begin : g_val
            localparam longint RCP = ((64'd1 << K) + c - 1) / c;
            assign recip_tbl[c] = RW'(RCP);
        end
    end

    logic [SW-1:0]     r_mem [BLOCK_COUNT];
    logic [SW-1:0]     r_rdata;
    logic [2:0]        r_state, n_state;
    logic [BCW-1:0]    r_clr;
    logic [SW-1:0]     r_acc;
    logic [PIX_W-1:0]  r_cur_pix;
    logic [BCW-1:0]    r_cur_bx;
    logic [CNTW-1:0]   r_cur_count;
    t_badsp_flags      r_cur_flags;
    logic [SW+RW-1:0]  r_prod;
    logic [PKW-1:0]    r_pack, n_pack;
    logic [2:0]        r_pcnt, n_pcnt;
    logic              r_ovld;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_olast, n_olast;

    logic              pop, need_rd, acc_go, out_free, out_load;
    logic [PIX_W-1:0]  cur_pix;
    logic [BCW-1:0]    cur_bx;
    t_badsp_flags      cur_flags;
    logic [SW-1:0]     base, sum;
    logic              mem_we;
    logic [BCW-1:0]    mem_wa;
    logic [SW-1:0]     mem_wd;
    logic [PIX_W-1:0]  avg;
    logic [3:0]        total;
    logic [2:0]        rem;
    logic [11:0]       combined;

    assign pop       = (r_state == B_RUN) && i_q_valid;
    assign o_q_pop   = pop;
    assign need_rd   = pop && i_flags.first && !i_flags.replace;
    assign acc_go    = (pop && !need_rd) || (r_state == B_ACC);
    assign cur_pix   = (r_state == B_ACC) ? r_cur_pix : i_pix;
    assign cur_bx    = (r_state == B_ACC) ? r_cur_bx : i_bx;
    assign cur_flags = (r_state == B_ACC) ? r_cur_flags : i_flags;
    assign base      = (r_state == B_ACC) ? r_rdata : (i_flags.first ? '0 : r_acc);
    assign sum       = base + SW'(cur_pix);
    assign out_free  = !r_ovld || i_out_ready;
    assign o_clr_done = (r_state != B_CLR);

    assign mem_we = (r_state == B_CLR) || (acc_go && cur_flags.seg_end);
    assign mem_wa = (r_state == B_CLR) ? r_clr : cur_bx;
    assign mem_wd = (r_state == B_CLR) ? '0 : sum;

    assign avg      = r_prod[K +: PIX_W];
    assign total    = {1'b0, r_pcnt} + 4'd5;
    assign rem      = total[2:0];
    assign combined = {r_pack, avg};

    always_comb begin
        n_state  = r_state;
        n_pack   = r_pack;
        n_pcnt   = r_pcnt;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        out_load = 1'b0;
        case (r_state)
            B_CLR: begin
                if (r_clr == BCW'(BLOCK_COUNT - 1)) begin
                    n_state = B_RUN;
                end
            end
            B_RUN, B_ACC: begin
                if (acc_go) begin
                    n_state = cur_flags.block_done ? B_MUL : B_RUN;
                end else if (need_rd) begin
                    n_state = B_ACC;
                end
            end
            B_MUL: begin
                n_state = B_PACK;
            end
            B_PACK: begin
                if (out_free) begin
                    n_state = B_RUN;
                    if (total[3]) begin
                        out_load = 1'b1;
                        n_obyte  = BYTE_W'(combined >> rem);
                        n_olast  = r_cur_flags.img_end && (rem == '0);
                        n_pack   = PKW'(combined & ((12'd1 << rem) - 12'd1));
                        n_pcnt   = rem;
                        if (r_cur_flags.img_end && rem != '0) begin
                            n_state = B_FLUSH;
                        end
                    end else if (r_cur_flags.img_end) begin
                        out_load = 1'b1;
                        n_obyte  = flush_byte(combined[PKW-1:0], total[2:0]);
                        n_olast  = 1'b1;
                        n_pack   = '0;
                        n_pcnt   = '0;
                    end else begin
                        n_pack = combined[PKW-1:0];
                        n_pcnt = total[2:0];
                    end
                end
            end
            B_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_obyte  = flush_byte(r_pack, r_pcnt);
                    n_olast  = 1'b1;
                    n_pack   = '0;
                    n_pcnt   = '0;
                    n_state  = B_RUN;
                end
            end
            default: begin
                n_state = B_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLR;
            r_clr   <= '0;
            r_pack  <= '0;
            r_pcnt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pack  <= n_pack;
            r_pcnt  <= n_pcnt;
            if (r_state == B_CLR) begin
                r_clr <= r_clr + BCW'(1);
            end
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        if (pop) begin
            r_cur_pix   <= i_pix;
            r_cur_bx    <= i_bx;
            r_cur_count <= i_count;
            r_cur_flags <= i_flags;
        end
        if (acc_go) begin
            r_acc <= sum;
        end
        if (r_state == B_MUL) begin
            r_prod <= (SW + RW)'(r_acc) * (SW + RW)'(recip_tbl[r_cur_count]);
        end
    end

    // Block sum memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (need_rd) begin
            r_rdata <= r_mem[i_bx];
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_packed_byte = r_obyte;
    assign o_last_byte   = r_olast;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLR) |-> !o_q_pop)
        else $error("queue popped during clearing pass");

    a_mul_then_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL) |=> (r_state == B_PACK))
        else $error("multiply not followed by pack");

    a_flush_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FLUSH) |-> (r_pcnt != '0))
        else $error("flush with empty pack register");

    a_last_clears_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_olast) |=> (r_pcnt == '0))
        else $error("pack state not cleared after last byte");

endmodule

// ===== rtl/block_average_downsample_pack.sv =====
// Top level of the 3x3 block average downsampler with 5-bit byte packing.
//
// Pixels (5-bit grey, raster order) enter one per clock, while the queue has room, into a
// four-request queue. The front end tracks column, row and block position against the
// configured width and height and tags every request; the back end accumulates each block,
// keeping partial sums of the current block row in a memory of ceil(MAX_WIDTH/BLOCK_SIZE)
// words, divides by the pixel count through a reciprocal table and one multiply, and packs
// the 5-bit averages MSB first into bytes. The back end takes each pixel in its run step;
// a pixel opening a block in a later row of its block row first reads its partial sum from
// memory, and each block ends with a multiply, then a pack step. The zero-padded flush
// byte at image end needs its own flush step only if the last average completes a byte
// with bits left over; if it completes none, the pack step emits it. A full output register
// holds the back end in the pack or flush step until the byte is taken. Input runs at 1
// pixel per cycle on the first row of a block row while the output does not stall, and
// slower on rows with memory reads or block ends; the queue absorbs bursts of up to four
// requests. After reset the block sum memory is zeroed (683 words at the defaults), during
// which no pixel is taken; configuration writes are taken at any time. Write the size
// registers only while the block is idle. The final byte of each image carries
// o_last_byte, after which position and packing state restart for the next image.
module block_average_downsample_pack #(
    parameter int MAX_WIDTH  = 2048,
    parameter int BLOCK_SIZE = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [badsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [badsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [badsp_pkg::PIX_W-1:0]      i_pixel_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [badsp_pkg::BYTE_W-1:0]     o_packed_byte,
    output logic                             o_last_byte
);
    import badsp_pkg::*;

    localparam int BLOCK_COUNT = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BCW  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CNTW = $clog2(BLOCK_SIZE * BLOCK_SIZE + 1);
    localparam int FW   = $bits(t_badsp_flags);
    localparam int QW   = PIX_W + BCW + CNTW + FW;
    localparam int QDEPTH = 4;

    // Front end to queue.
    logic              f_push, q_full, clr_done;
    logic [PIX_W-1:0]  f_pix;
    logic [BCW-1:0]    f_bx;
    logic [CNTW-1:0]   f_count;
    t_badsp_flags      f_flags;

    // Queue to back end.
    logic              q_valid, q_pop;
    logic [QW-1:0]     q_wdata, q_rdata;
    logic [PIX_W-1:0]  b_pix;
    logic [BCW-1:0]    b_bx;
    logic [CNTW-1:0]   b_count;
    t_badsp_flags      b_flags;

    badsp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .BLOCK_SIZE (BLOCK_SIZE),
        .BCW        (BCW),
        .CNTW       (CNTW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_value (i_pixel_value),
        .i_clr_done    (clr_done),
        .i_q_full      (q_full),
        .o_q_push      (f_push),
        .o_pix         (f_pix),
        .o_bx          (f_bx),
        .o_count       (f_count),
        .o_flags       (f_flags)
    );

    // Pack each tagged pixel request for the queue.
    assign q_wdata = {f_pix, f_bx, f_count, f_flags};

    badsp_fifo #(
        .W     (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {b_pix, b_bx, b_count, b_flags} = q_rdata;

    badsp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .BLOCK_SIZE (BLOCK_SIZE),
        .BCW        (BCW),
        .CNTW       (CNTW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_pix         (b_pix),
        .i_bx          (b_bx),
        .i_count       (b_count),
        .i_flags       (b_flags),
        .o_clr_done    (clr_done),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packed_byte (o_packed_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule
